>>> rtl/bps_pkg.sv
// bps_pkg: shared types, sizes and codes of the button pattern sequencer.
// Used by bps_front, bps_back and button_pattern_sequencer; depends on nothing.

package bps_pkg;

    localparam int MAX_SEQUENCES = 4;
    localparam int MAX_SECTIONS  = 16;
    localparam int NUM_OUTPUTS   = 8;

    localparam int STORE_DEPTH = MAX_SEQUENCES * MAX_SECTIONS;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int SEQ_W       = (MAX_SEQUENCES > 1) ? $clog2(MAX_SEQUENCES) : 1;
    localparam int SEC_W       = $clog2(MAX_SECTIONS);
    localparam int ENTRY_W     = 17;
    // delay plus every section of one sequence
    localparam int ELAPSED_W   = 16 + $clog2(MAX_SECTIONS + 1);

    localparam int CMD_DEPTH   = 2;
    localparam int CMD_PTR_W   = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int CMD_CNT_W   = $clog2(CMD_DEPTH + 1);

    localparam logic       OP_TICK  = 1'b0;
    localparam logic       OP_WRITE = 1'b1;

    localparam logic [1:0] PH_WAIT_PRESS   = 2'd0;
    localparam logic [1:0] PH_WAIT_RELEASE = 2'd1;
    localparam logic [1:0] PH_PLAY         = 2'd2;

    localparam logic [2:0] CFG_PROGRAM_MODE      = 3'd0;
    localparam logic [2:0] CFG_DEFAULT_OUTPUT    = 3'd1;
    localparam logic [2:0] CFG_SEQUENCE_COUNT    = 3'd2;
    localparam logic [2:0] CFG_TOTAL_PLAY_TIME   = 3'd3;
    localparam logic [2:0] CFG_SEQUENCE_CHANNELS = 3'd4;
    localparam logic [2:0] CFG_SEQUENCE_DELAYS   = 3'd5;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_IGNORE = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        logic        opcode;
        logic        button;
        logic [31:0] time_ms;
        logic [1:0]  seq_index;
        logic [3:0]  section_index;
        logic        section_on;
        logic [15:0] section_duration;
    } t_in_item;

    typedef struct packed {
        logic [7:0] pressed_mask;
        logic [1:0] ctrl_state;
    } t_out_item;

    typedef struct packed {
        t_cmd_kind          kind;
        logic               button;
        logic [31:0]        time_ms;
        logic [ADDR_W-1:0]  addr;
        logic [ENTRY_W-1:0] entry;
    } t_cmd;

    typedef struct packed {
        logic        program_mode;
        logic [2:0]  default_output;
        logic [2:0]  sequence_count;
        logic [30:0] total_play_time;
        logic [15:0] sequence_channels;
        logic [63:0] sequence_delays;
    } t_cfg;

endpackage

>>> rtl/bps_front.sv
// bps_front: accepts input items, decodes them into commands and queues them.
// Depends on bps_pkg for the item and command types.

module bps_front import bps_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     push,
    output logic     full,
    input  t_in_item i_item,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_cmd_take
);

    t_cmd                 r_queue [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wp, n_wp;
    logic [CMD_PTR_W-1:0] r_rp, n_rp;
    logic [CMD_CNT_W-1:0] r_count, n_count;
    t_cmd                 cmd_in;
    logic                 do_push;
    logic                 do_pop;

    // classify: writes with an index outside the store turn into no-ops
    always_comb begin
        cmd_in.button  = i_item.button;
        cmd_in.time_ms = i_item.time_ms;
        cmd_in.entry   = {i_item.section_on, i_item.section_duration};
        cmd_in.addr    = ADDR_W'(int'(i_item.seq_index) * MAX_SECTIONS
                                 + int'(i_item.section_index));
        unique case (i_item.opcode)
            OP_TICK:  cmd_in.kind = CMD_TICK;
            OP_WRITE: begin
                if (int'(i_item.seq_index) < MAX_SEQUENCES &&
                    int'(i_item.section_index) < MAX_SECTIONS) begin
                    cmd_in.kind = CMD_WRITE;
                end else begin
                    cmd_in.kind = CMD_IGNORE;
                end
            end
            default:  cmd_in.kind = CMD_TICK;
        endcase
    end

    assign full        = (r_count == CMD_CNT_W'(CMD_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_queue[r_rp];
    assign do_push     = push && !full;
    assign do_pop      = i_cmd_take && o_cmd_valid;

    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (do_push) begin
            n_wp = (r_wp == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_queue[r_wp] <= cmd_in;
        end
    end

endmodule

>>> rtl/bps_back.sv
// bps_back: carries out queued commands: section store, phase control, section walk
// and the result register. Depends on bps_pkg.

module bps_back import bps_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_phase_clr,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_take,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_result
);

    typedef enum logic [2:0] {
        E_IDLE = 3'b001,
        E_WALK = 3'b010,
        E_DONE = 3'b100
    } t_eng_state;

    t_eng_state           r_state, n_state;
    logic [1:0]           r_phase, n_phase;
    logic [31:0]          r_start, n_start;
    logic [31:0]          r_play, n_play;
    logic [7:0]           r_out_vld, n_out_vld;
    logic [7:0]           r_out_prs, n_out_prs;
    logic [SEQ_W-1:0]     r_s, n_s;
    logic [SEC_W-1:0]     r_k, n_k;
    logic [ELAPSED_W-1:0] r_elapsed, n_elapsed;
    logic                 r_level, n_level;
    logic                 r_res_vld, n_res_vld;
    t_out_item            r_res;

    logic [ENTRY_W-1:0]   r_mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] r_entry_vld;
    logic [ENTRY_W-1:0]   r_rd_data;
    logic                 r_rd_vld;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 mem_we;

    logic [2:0]           seq_n;
    logic [31:0]          play_now;
    logic [15:0]          cur_dur;
    logic                 cur_on;
    logic                 stop;
    logic                 seq_end;
    logic [2:0]           cur_ch;

    function automatic logic [15:0] lane_delay(input logic [63:0] d, input logic [SEQ_W-1:0] s);
        logic [15:0] v;
        v = '0;
        for (int i = 0; i < 4; i++) begin
            if (int'(s) == i) v = d[16*i +: 16];
        end
        return v;
    endfunction

    function automatic logic [2:0] lane_channel(input t_cfg c, input logic [SEQ_W-1:0] s);
        logic [3:0] sel;
        sel = '0;
        for (int i = 0; i < 4; i++) begin
            if (int'(s) == i) sel = c.sequence_channels[4*i +: 4];
        end
        return sel[3] ? c.default_output : sel[2:0];
    endfunction

    function automatic logic [ADDR_W-1:0] store_addr(input logic [SEQ_W-1:0] s,
                                                     input logic [SEC_W-1:0] k);
        return ADDR_W'(int'(s) * MAX_SECTIONS + int'(k));
    endfunction

    // active sequences, limited to the store and to the four lanes
    always_comb begin
        seq_n = i_cfg.sequence_count;
        if (int'(seq_n) > MAX_SEQUENCES) seq_n = 3'(MAX_SEQUENCES);
        if (seq_n > 3'd4) seq_n = 3'd4;
    end

    assign play_now = i_cmd.time_ms - r_start;
    // a never-written entry reads as zero
    assign cur_dur  = r_rd_vld ? r_rd_data[15:0] : 16'd0;
    assign cur_on   = r_rd_vld ? r_rd_data[16] : 1'b0;
    assign stop     = ({{(32-ELAPSED_W){1'b0}}, r_elapsed} > r_play) || (cur_dur == 16'd0);
    assign seq_end  = stop || (r_k == SEC_W'(MAX_SECTIONS - 1));
    assign cur_ch   = lane_channel(i_cfg, r_s);

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_start   = r_start;
        n_play    = r_play;
        n_out_vld = r_out_vld;
        n_out_prs = r_out_prs;
        n_s       = r_s;
        n_k       = r_k;
        n_elapsed = r_elapsed;
        n_level   = r_level;
        n_res_vld = r_res_vld;
        o_cmd_take = 1'b0;
        mem_we    = 1'b0;

        if (pop && r_res_vld) n_res_vld = 1'b0;

        unique case (r_state)
            E_IDLE: begin
                if (i_cmd_valid && !r_res_vld) begin
                    o_cmd_take = 1'b1;
                    n_state    = E_DONE;
                    case (i_cmd.kind)
                        CMD_WRITE: mem_we = 1'b1;
                        CMD_TICK: begin
                            if (!i_cfg.program_mode) begin
                                if (int'(i_cfg.default_output) < NUM_OUTPUTS) begin
                                    n_out_vld[i_cfg.default_output] = 1'b1;
                                    n_out_prs[i_cfg.default_output] = i_cmd.button;
                                end
                            end else begin
                                case (r_phase)
                                    PH_WAIT_PRESS: begin
                                        if (i_cmd.button) begin
                                            n_phase = PH_PLAY;
                                            n_start = i_cmd.time_ms;
                                        end
                                    end
                                    PH_WAIT_RELEASE: begin
                                        if (!i_cmd.button) n_phase = PH_WAIT_PRESS;
                                    end
                                    PH_PLAY: begin
                                        if (play_now > {1'b0, i_cfg.total_play_time}) begin
                                            n_phase = PH_WAIT_RELEASE;
                                        end else begin
                                            n_out_vld = '0;
                                            n_out_prs = '0;
                                            n_play    = play_now;
                                            n_s       = '0;
                                            n_k       = '0;
                                            n_level   = 1'b0;
                                            n_elapsed = ELAPSED_W'(lane_delay(
                                                            i_cfg.sequence_delays, '0));
                                            if (seq_n != 3'd0) n_state = E_WALK;
                                        end
                                    end
                                    default: ;
                                endcase
                            end
                        end
                        default: ;
                    endcase
                end
            end
            E_WALK: begin
                if (!stop) begin
                    n_level   = cur_on;
                    n_elapsed = r_elapsed + ELAPSED_W'(cur_dur);
                end
                if (seq_end) begin
                    if (int'(cur_ch) < NUM_OUTPUTS) begin
                        n_out_vld[cur_ch] = 1'b1;
                        n_out_prs[cur_ch] = stop ? r_level : cur_on;
                    end
                    if (int'(r_s) == int'(seq_n) - 1) begin
                        n_state = E_DONE;
                    end else begin
                        // next sequence: fresh delay, level low
                        n_s       = r_s + 1'b1;
                        n_k       = '0;
                        n_level   = 1'b0;
                        n_elapsed = ELAPSED_W'(lane_delay(i_cfg.sequence_delays,
                                                          r_s + 1'b1));
                    end
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            E_DONE: begin
                n_res_vld = 1'b1;
                n_state   = E_IDLE;
            end
            default: n_state = E_IDLE;
        endcase

        if (i_phase_clr) n_phase = PH_WAIT_PRESS;
    end

    // the read runs one section ahead of the walk
    assign rd_addr = store_addr(n_s, n_k);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= E_IDLE;
            r_phase     <= PH_WAIT_RELEASE;
            r_start     <= '0;
            r_out_vld   <= '0;
            r_out_prs   <= '0;
            r_res_vld   <= 1'b0;
            r_entry_vld <= '0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_start   <= n_start;
            r_out_vld <= n_out_vld;
            r_out_prs <= n_out_prs;
            r_res_vld <= n_res_vld;
            if (mem_we) r_entry_vld[i_cmd.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_play    <= n_play;
        r_s       <= n_s;
        r_k       <= n_k;
        r_elapsed <= n_elapsed;
        r_level   <= n_level;
        r_rd_vld  <= r_entry_vld[rd_addr];
        if (r_state == E_DONE) begin
            r_res.pressed_mask <= r_out_vld & r_out_prs;
            r_res.ctrl_state   <= r_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[i_cmd.addr] <= i_cmd.entry;
        r_rd_data <= r_mem[rd_addr];
    end

    assign empty    = !r_res_vld;
    assign o_result = r_res;

endmodule

>>> rtl/button_pattern_sequencer.sv
// button_pattern_sequencer: top level with the configuration registers.
// Instantiates bps_front and bps_back; depends on bps_pkg.
//
// channel   direction  handshake                 payload
// input     in         push / full               i_item   (t_in_item)
// result    out        empty / pop               o_result (t_out_item)
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// Outside playback, a write or a tick goes via the queue and the back's done state to a result.
// A playback tick also walks the store through the single read port, one entry at a time:
// one up to MAX_SECTIONS per active sequence, 64 at most.
// On reset the store's valid bits clear at once, with no clearing pass.
// Two commands queue between the front and the back, so push goes on while a result
// waits for pop, until the queue fills; a held result stalls only the back.

module button_pattern_sequencer import bps_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  t_in_item    i_item,
    output logic        empty,
    input  logic        pop,
    output t_out_item   o_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    t_cfg r_cfg;
    logic cfg_wr;
    logic phase_clr;
    logic cmd_valid;
    logic cmd_take;
    t_cmd cmd;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign phase_clr   = cfg_wr && (i_cfg_index == CFG_PROGRAM_MODE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.program_mode      <= 1'b0;
            r_cfg.default_output    <= '0;
            r_cfg.sequence_count    <= '0;
            r_cfg.total_play_time   <= '0;
            r_cfg.sequence_channels <= 16'hFFFF;
            r_cfg.sequence_delays   <= '0;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_PROGRAM_MODE:      r_cfg.program_mode      <= i_cfg_data[0];
                CFG_DEFAULT_OUTPUT:    r_cfg.default_output    <= i_cfg_data[2:0];
                CFG_SEQUENCE_COUNT:    r_cfg.sequence_count    <= i_cfg_data[2:0];
                CFG_TOTAL_PLAY_TIME:   r_cfg.total_play_time   <= i_cfg_data[30:0];
                CFG_SEQUENCE_CHANNELS: r_cfg.sequence_channels <= i_cfg_data[15:0];
                CFG_SEQUENCE_DELAYS:   r_cfg.sequence_delays   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bps_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    bps_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_phase_clr (phase_clr),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result)
    );

endmodule
